// File: design/ssfe_pkg.sv
// ----------------------------------------------------------------------------
// ssfe_pkg
// Shared types, segment constants and glyph tables for the seven-segment
// frame encoder.
// ----------------------------------------------------------------------------
package ssfe_pkg;

  // Request commands.
  localparam logic [1:0] CMD_NUMBER = 2'd0;
  localparam logic [1:0] CMD_TIME   = 2'd1;
  localparam logic [1:0] CMD_CHARS  = 2'd2;

  // Segment bits of the driver's segment byte.
  localparam logic [7:0] SEG_A   = 8'h10;
  localparam logic [7:0] SEG_B   = 8'h40;
  localparam logic [7:0] SEG_C   = 8'h02;
  localparam logic [7:0] SEG_D   = 8'h04;
  localparam logic [7:0] SEG_E   = 8'h08;
  localparam logic [7:0] SEG_F   = 8'h20;
  localparam logic [7:0] SEG_G   = 8'h01;
  localparam logic [7:0] SEG_DOT = 8'h80;

  // Active-low digit select nibbles.
  localparam logic [3:0] SEL_POS1 = 4'b1101;
  localparam logic [3:0] SEL_POS2 = 4'b1011;
  localparam logic [3:0] SEL_POS3 = 4'b0111;
  localparam logic [3:0] SEL_POS4 = 4'b1110;

  // Filler bits between select nibble and segment byte.
  localparam logic [5:0] FRAME_FILL = 6'b111111;

  localparam logic [2:0] POS_FIRST = 3'd1;
  localparam logic [2:0] POS_LAST  = 3'd4;

  localparam logic [13:0] NUM_MAX = 14'd9999;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] number_value;
    logic signed [15:0] hours_value;
    logic signed [15:0] minutes_value;
    logic [7:0]         char_one;
    logic [7:0]         char_two;
    logic [7:0]         char_three;
    logic [7:0]         char_four;
  } ssfe_req_t;

  typedef struct packed {
    logic [2:0]  digit_position;
    logic [3:0]  select_nibble;
    logic [7:0]  segment_byte;
    logic [17:0] serial_frame;
    logic        last_frame;
  } ssfe_frame_t;

  // Work item passed along the pipeline.
  typedef struct packed {
    logic            is_num;
    logic [13:0]     num;
    logic [2:0]      start_pos;
    logic [3:0][7:0] glyph;
  } ssfe_work_t;

  // Decimal digit at the given weight for a value below ten times the weight.
  function automatic logic [3:0] ssfe_quot(input logic [13:0] v, input logic [13:0] unit);
    logic [3:0] q;
    q = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (v >= 14'(k) * unit) q = 4'(k);
    end
    return q;
  endfunction

  function automatic logic [7:0] ssfe_digit_glyph(input logic [3:0] d);
    logic [7:0] g;
    case (d)
      4'd0:    g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
      4'd1:    g = SEG_B | SEG_C;
      4'd2:    g = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
      4'd3:    g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
      4'd4:    g = SEG_B | SEG_C | SEG_F | SEG_G;
      4'd5:    g = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;
      4'd6:    g = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
      4'd7:    g = SEG_A | SEG_B | SEG_C;
      4'd8:    g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
      4'd9:    g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
      default: g = SEG_G;
    endcase
    return g;
  endfunction

  function automatic logic [7:0] ssfe_char_glyph(input logic [7:0] ch);
    logic [7:0] g;
    case (ch)
      "0":     g = ssfe_digit_glyph(4'd0);
      "1":     g = ssfe_digit_glyph(4'd1);
      "2":     g = ssfe_digit_glyph(4'd2);
      "3":     g = ssfe_digit_glyph(4'd3);
      "4":     g = ssfe_digit_glyph(4'd4);
      "5":     g = ssfe_digit_glyph(4'd5);
      "6":     g = ssfe_digit_glyph(4'd6);
      "7":     g = ssfe_digit_glyph(4'd7);
      "8":     g = ssfe_digit_glyph(4'd8);
      "9":     g = ssfe_digit_glyph(4'd9);
      "A":     g = SEG_A | SEG_B | SEG_C | SEG_E | SEG_F | SEG_G;
      "b":     g = SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
      "c":     g = SEG_D | SEG_E | SEG_G;
      "C":     g = SEG_A | SEG_D | SEG_E | SEG_F;
      "d":     g = SEG_B | SEG_C | SEG_D | SEG_E | SEG_G;
      "E":     g = SEG_A | SEG_D | SEG_E | SEG_F | SEG_G;
      "e":     g = SEG_A | SEG_B | SEG_D | SEG_E | SEG_F | SEG_G;
      "F":     g = SEG_A | SEG_E | SEG_F | SEG_G;
      "g":     g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
      "H":     g = SEG_B | SEG_C | SEG_E | SEG_F | SEG_G;
      "I":     g = SEG_E | SEG_F;
      "i":     g = SEG_E;
      "J":     g = SEG_B | SEG_C | SEG_D | SEG_E;
      "L":     g = SEG_D | SEG_E | SEG_F;
      "n":     g = SEG_C | SEG_E | SEG_G;
      "o":     g = SEG_C | SEG_D | SEG_E | SEG_G;
      "P":     g = SEG_A | SEG_B | SEG_E | SEG_F | SEG_G;
      "r":     g = SEG_E | SEG_G;
      "S":     g = SEG_A | SEG_F | SEG_G | SEG_C | SEG_D;
      "t":     g = SEG_D | SEG_E | SEG_F | SEG_G;
      "U":     g = SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
      "y":     g = SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
      " ":     g = 8'h00;
      default: g = SEG_G;
    endcase
    return g;
  endfunction

endpackage

// File: design/ssfe_front.sv
// ----------------------------------------------------------------------------
// ssfe_front
// First pipeline stage: captures a request, clamps the number, builds the
// time and character glyphs and picks the first display position.
// ----------------------------------------------------------------------------
module ssfe_front import ssfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  ssfe_req_t  req,
  output logic       busy,
  output logic       out_valid,
  output ssfe_work_t out_work,
  input  logic       out_ready
);

  logic       valid;
  ssfe_work_t work;
  ssfe_work_t work_next;
  logic       accept;
  logic [13:0] num_clamped;
  logic [13:0] hours;
  logic [13:0] minutes;
  logic [3:0]  h_tens;
  logic [3:0]  h_ones;
  logic [3:0]  m_tens;
  logic [3:0]  m_ones;

  assign busy   = valid && !out_ready;
  assign accept = start && !busy;

  always_comb begin
    if (req.number_value < 0) begin
      num_clamped = 14'd0;
    end else if (req.number_value > 16'sd9999) begin
      num_clamped = NUM_MAX;
    end else begin
      num_clamped = req.number_value[13:0];
    end

    if (req.hours_value < 0 || req.hours_value > 16'sd23) begin
      hours = 14'd0;
    end else begin
      hours = req.hours_value[13:0];
    end
    if (req.minutes_value < 0 || req.minutes_value > 16'sd59) begin
      minutes = 14'd0;
    end else begin
      minutes = req.minutes_value[13:0];
    end

    h_tens = ssfe_quot(hours, 14'd10);
    h_ones = 4'(hours - 14'(h_tens) * 14'd10);
    m_tens = ssfe_quot(minutes, 14'd10);
    m_ones = 4'(minutes - 14'(m_tens) * 14'd10);

    work_next.is_num = (req.cmd == CMD_NUMBER);
    work_next.num    = num_clamped;
    if (req.cmd != CMD_NUMBER || num_clamped >= 14'd1000) begin
      work_next.start_pos = POS_FIRST;
    end else if (num_clamped >= 14'd100) begin
      work_next.start_pos = 3'd2;
    end else if (num_clamped >= 14'd10) begin
      work_next.start_pos = 3'd3;
    end else begin
      work_next.start_pos = POS_LAST;
    end

    if (req.cmd == CMD_TIME) begin
      work_next.glyph[0] = ssfe_digit_glyph(h_tens);
      work_next.glyph[1] = ssfe_digit_glyph(h_ones) | SEG_DOT;
      work_next.glyph[2] = ssfe_digit_glyph(m_tens);
      work_next.glyph[3] = ssfe_digit_glyph(m_ones);
    end else begin
      work_next.glyph[0] = ssfe_char_glyph(req.char_one);
      work_next.glyph[1] = ssfe_char_glyph(req.char_two);
      work_next.glyph[2] = ssfe_char_glyph(req.char_three);
      work_next.glyph[3] = ssfe_char_glyph(req.char_four);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      // The undefined command is taken and dropped here.
      valid <= (req.cmd == CMD_NUMBER) || (req.cmd == CMD_TIME) || (req.cmd == CMD_CHARS);
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      work <= work_next;
    end
  end

  assign out_valid = valid;
  assign out_work  = work;

endmodule

// File: design/ssfe_digits.sv
// ----------------------------------------------------------------------------
// ssfe_digits
// Three stages that split the clamped number into decimal digits (thousands,
// hundreds, then tens and ones) and fill in digit glyphs for number requests.
// ----------------------------------------------------------------------------
module ssfe_digits import ssfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  ssfe_work_t in_work,
  output logic       in_ready,
  output logic       out_valid,
  output ssfe_work_t out_work,
  input  logic       out_ready
);

  typedef struct packed {
    ssfe_work_t  w;
    logic [3:0]  d0;
    logic [9:0]  rem;
  } thou_t;

  typedef struct packed {
    ssfe_work_t  w;
    logic [3:0]  d0;
    logic [3:0]  d1;
    logic [6:0]  rem;
  } hund_t;

  logic       v2;
  logic       v3;
  logic       v4;
  logic       r2;
  logic       r3;
  logic       r4;
  thou_t      s2;
  thou_t      s2_next;
  hund_t      s3;
  hund_t      s3_next;
  ssfe_work_t s4;
  ssfe_work_t s4_next;
  logic [3:0] d2;
  logic [3:0] d3;

  assign r4       = !v4 || out_ready;
  assign r3       = !v3 || r4;
  assign r2       = !v2 || r3;
  assign in_ready = r2;

  always_comb begin
    s2_next.w   = in_work;
    s2_next.d0  = ssfe_quot(in_work.num, 14'd1000);
    s2_next.rem = 10'(in_work.num - 14'(s2_next.d0) * 14'd1000);

    s3_next.w   = s2.w;
    s3_next.d0  = s2.d0;
    s3_next.d1  = ssfe_quot(14'(s2.rem), 14'd100);
    s3_next.rem = 7'(14'(s2.rem) - 14'(s3_next.d1) * 14'd100);

    d2 = ssfe_quot(14'(s3.rem), 14'd10);
    d3 = 4'(14'(s3.rem) - 14'(d2) * 14'd10);

    s4_next = s3.w;
    if (s3.w.is_num) begin
      s4_next.glyph[0] = ssfe_digit_glyph(s3.d0);
      s4_next.glyph[1] = ssfe_digit_glyph(s3.d1);
      s4_next.glyph[2] = ssfe_digit_glyph(d2);
      s4_next.glyph[3] = ssfe_digit_glyph(d3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r2) v2 <= in_valid;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r2 && in_valid) s2 <= s2_next;
    if (r3 && v2)       s3 <= s3_next;
    if (r4 && v3)       s4 <= s4_next;
  end

  assign out_valid = v4;
  assign out_work  = s4;

endmodule

// File: design/ssfe_serializer.sv
// ----------------------------------------------------------------------------
// ssfe_serializer
// Holds one finished item and sends its frames, one per cycle, from the
// first used position up to position four.
// ----------------------------------------------------------------------------
module ssfe_serializer import ssfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  ssfe_work_t  in_work,
  output logic        in_ready,
  output logic        strobe,
  output ssfe_frame_t result
);

  logic            active;
  logic [2:0]      pos;
  logic [3:0][7:0] glyph;
  logic            take;
  logic            at_last;
  logic [1:0]      idx;
  logic [3:0]      sel;

  assign at_last  = (pos == POS_LAST);
  assign take     = !active || at_last;
  assign in_ready = take;
  assign idx      = 2'(pos - POS_FIRST);

  always_comb begin
    case (pos)
      3'd1:    sel = SEL_POS1;
      3'd2:    sel = SEL_POS2;
      3'd3:    sel = SEL_POS3;
      default: sel = SEL_POS4;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pos    <= POS_LAST;
    end else if (take) begin
      active <= in_valid;
      if (in_valid) pos <= in_work.start_pos;
    end else begin
      pos <= pos + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) glyph <= in_work.glyph;
  end

  assign strobe                = active;
  assign result.digit_position = pos;
  assign result.select_nibble  = sel;
  assign result.segment_byte   = glyph[idx];
  assign result.serial_frame   = {sel, FRAME_FILL, glyph[idx]};
  assign result.last_frame     = at_last;

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    active |-> (pos >= POS_FIRST && pos <= POS_LAST))
    else $error("frame position out of range");

  a_frames_run: assert property (@(posedge clk) disable iff (rst)
    (active && !at_last) |=> (active && pos == $past(pos) + 3'd1))
    else $error("frame run broken before last position");

  a_load: assert property (@(posedge clk) disable iff (rst)
    (take && in_valid) |=> (active && pos == $past(in_work.start_pos)))
    else $error("offered item not loaded");

endmodule

// File: design/seven_segment_frame_encoder.sv
// ----------------------------------------------------------------------------
// seven_segment_frame_encoder
// Turns one display request into the 18-bit serial frames of a 4-digit
// seven-segment shift driver.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake        Payload            Direction
//  --------  ---------------  -----------------  ---------
//  request   start / busy     req (ssfe_req_t)     in
//  frame     strobe           result (ssfe_frame_t) out
//
// An item is taken at a rising edge where start is high and busy is low.
// It passes five register stages: capture and clamping, the thousands,
// hundreds and tens/ones digit stages, and the frame serializer. The first
// frame reaches the result ports after the capture register, the digit
// registers and the serializer; frames then follow one per cycle.
// Time and character requests give four frames, number requests one
// to four. The serializer takes the next item while it shows the last frame
// of the current one. The undefined command is taken and gives no frame.
// Reset clears only the valid bits and the serializer's frame position.
// The receiver cannot stall: each frame stands for exactly one cycle under
// strobe. Backlog in the serializer stalls the digit stages, and busy rises
// once the capture stage cannot move on.
// ----------------------------------------------------------------------------
module seven_segment_frame_encoder import ssfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  ssfe_req_t   req,
  output logic        busy,
  output logic        strobe,
  output ssfe_frame_t result
);

  // Capture stage to digit stages.
  logic       front_valid;
  ssfe_work_t front_work;
  logic       digits_ready;

  // Digit stages to serializer.
  logic       digits_valid;
  ssfe_work_t digits_work;
  logic       ser_ready;

  ssfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .busy      (busy),
    .out_valid (front_valid),
    .out_work  (front_work),
    .out_ready (digits_ready)
  );

  ssfe_digits u_digits (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_work   (front_work),
    .in_ready  (digits_ready),
    .out_valid (digits_valid),
    .out_work  (digits_work),
    .out_ready (ser_ready)
  );

  ssfe_serializer u_serializer (
    .clk      (clk),
    .rst      (rst),
    .in_valid (digits_valid),
    .in_work  (digits_work),
    .in_ready (ser_ready),
    .strobe   (strobe),
    .result   (result)
  );

endmodule
